@@ rtl/spq_pkg.sv @@
package spq_pkg;

   // Queue geometry
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VAL_W   = 32;
   localparam int PRIO_W  = 16;
   localparam int TOTAL_W = 5;
   localparam int FAULT_W = 2;

   // Command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Fault codes
   localparam logic [FAULT_W-1:0] FAULT_OK        = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd2;

   // Controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // apply the captured operation and register the result
   } ctrl_cmd_type;

endpackage

@@ rtl/spq_ctrl.sv @@
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   assign busy       = (state_ff == ST_EXEC);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign cmd.load   = start && !busy;
   assign cmd.exec   = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Busy lasts exactly one cycle per transfer
   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   // A result strobe always follows an execute cycle
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.exec))
      else $error("result strobe without preceding execute");

   // An accepted request is executed in the next cycle
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted request not executed");

endmodule

@@ rtl/spq_datapath.sv @@
module spq_datapath
   import spq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   input  logic                      req_command,
   input  logic signed [VAL_W-1:0]   req_item_value,
   input  logic        [PRIO_W-1:0]  req_item_priority,
   output logic signed [VAL_W-1:0]   rsp_removed_value,
   output logic signed [VAL_W-1:0]   rsp_front_value,
   output logic                      rsp_queue_empty,
   output logic        [TOTAL_W-1:0] rsp_entry_total,
   output logic        [FAULT_W-1:0] rsp_fault_code
);

   // Captured request
   logic                     command_ff;
   logic signed [VAL_W-1:0]  value_ff;
   logic        [PRIO_W-1:0] prio_ff;

   // Sorted slot chain
   logic signed [VAL_W-1:0]  slot_val_ff  [DEPTH];
   logic signed [VAL_W-1:0]  slot_val_in  [DEPTH];
   logic        [PRIO_W-1:0] slot_prio_ff [DEPTH];
   logic        [PRIO_W-1:0] slot_prio_in [DEPTH];
   logic        [CNT_W-1:0]  count_ff;
   logic        [CNT_W-1:0]  count_in;

   // Result registers
   logic signed [VAL_W-1:0]   removed_ff;
   logic signed [VAL_W-1:0]   removed_in;
   logic signed [VAL_W-1:0]   front_ff;
   logic signed [VAL_W-1:0]   front_in;
   logic                      empty_ff;
   logic        [TOTAL_W-1:0] total_ff;
   logic        [FAULT_W-1:0] fault_ff;
   logic        [FAULT_W-1:0] fault_in;

   logic [DEPTH-1:0] keep;

   // Per-slot stay decision; the head also stays on a tie
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            keep[i] = (count_ff > CNT_W'(i)) && (slot_prio_ff[i] <= prio_ff);
         end else begin
            keep[i] = (count_ff > CNT_W'(i)) && (slot_prio_ff[i] < prio_ff);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_val_in[i]  = slot_val_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
      end
      count_in   = count_ff;
      removed_in = '0;
      fault_in   = FAULT_OK;

      if (command_ff == CMD_PUSH) begin
         if (count_ff >= CNT_W'(DEPTH)) begin
            fault_in = FAULT_OVERFLOW;
         end else begin
            // Insert at the first slot that does not stay; shift the rest up
            for (int i = 0; i < DEPTH; i++) begin
               if (!keep[i]) begin
                  if (i == 0) begin
                     slot_val_in[i]  = value_ff;
                     slot_prio_in[i] = prio_ff;
                  end else if (keep[i-1]) begin
                     slot_val_in[i]  = value_ff;
                     slot_prio_in[i] = prio_ff;
                  end else begin
                     slot_val_in[i]  = slot_val_ff[i-1];
                     slot_prio_in[i] = slot_prio_ff[i-1];
                  end
               end
            end
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (count_ff == '0) begin
            fault_in = FAULT_UNDERFLOW;
         end else begin
            // Drop the head and advance the chain
            removed_in = slot_val_ff[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot_val_in[i]  = slot_val_ff[i+1];
               slot_prio_in[i] = slot_prio_ff[i+1];
            end
            count_in = count_ff - CNT_W'(1);
         end
      end

      front_in = (count_in != '0) ? slot_val_in[0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         value_ff   <= req_item_value;
         prio_ff    <= req_item_priority;
      end
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_val_ff[i]  <= slot_val_in[i];
            slot_prio_ff[i] <= slot_prio_in[i];
         end
         removed_ff <= removed_in;
         front_ff   <= front_in;
         empty_ff   <= (count_in == '0);
         total_ff   <= TOTAL_W'(count_in);
         fault_ff   <= fault_in;
      end
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_front_value   = front_ff;
   assign rsp_queue_empty   = empty_ff;
   assign rsp_entry_total   = total_ff;
   assign rsp_fault_code    = fault_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds depth");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (slot_prio_ff[0] <= slot_prio_ff[1]))
      else $error("head priority out of order");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && command_ff == CMD_POP && count_ff == '0)
      |=> (rsp_fault_code == FAULT_UNDERFLOW) && (count_ff == '0))
      else $error("pop on empty queue not flagged");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && command_ff == CMD_PUSH && count_ff < CNT_W'(DEPTH))
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow occupancy");

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Channel   Ports                                   Transfer
// request   start, busy, req_command,               start high and busy low at a rising edge
//           req_item_value, req_item_priority
// result    rsp_strobe, rsp_removed_value,          one cycle with rsp_strobe high
//           rsp_front_value, rsp_queue_empty,
//           rsp_entry_total, rsp_fault_code
//
// An accepted request executes in the next cycle, when all DEPTH slots compare
// against the new priority at once and the slot chain shifts in one step.
// The result strobes in the cycle after that; a new request may be accepted in
// the strobe cycle, but never while busy is high during the execute cycle.
// Synchronous reset empties the queue; slot contents are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_command,
   input  logic signed [VAL_W-1:0]   req_item_value,
   input  logic        [PRIO_W-1:0]  req_item_priority,
   output logic                      rsp_strobe,
   output logic signed [VAL_W-1:0]   rsp_removed_value,
   output logic signed [VAL_W-1:0]   rsp_front_value,
   output logic                      rsp_queue_empty,
   output logic        [TOTAL_W-1:0] rsp_entry_total,
   output logic        [FAULT_W-1:0] rsp_fault_code
);

   ctrl_cmd_type cmd;

   // Sequence each transfer: capture, execute, strobe
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Hold the sorted slots and build the result word
   spq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_command       (req_command),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_entry_total   (rsp_entry_total),
      .rsp_fault_code    (rsp_fault_code)
   );

endmodule
